>>> hw/rtl/mlfq_pkg.sv
// Shared types, codes and default sizes for the multilevel feedback queue.
`default_nettype none

package mlfq_pkg;

  localparam int DEF_NUM_LEVELS = 8;
  localparam int DEF_POOL_SLOTS = 64;
  localparam int DEF_PID_BITS   = 16;

  typedef enum logic [1:0] {
    OP_ADMIT    = 2'd0,
    OP_DEMOTE   = 2'd1,
    OP_TERM     = 2'd2,
    OP_TERM_LVL = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_BOTTOM   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_PASS = 2'd1,
    S_DONE = 2'd2
  } state_t;

  typedef enum logic [1:0] {
    MODE_COPY  = 2'd0,
    MODE_LOOK  = 2'd1,
    MODE_CARRY = 2'd2
  } mode_t;

  typedef struct packed {
    op_t         operation;
    logic [15:0] process_id;
    logic [2:0]  level;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [2:0]  result_level;
    logic [15:0] result_pid;
    logic [6:0]  total_count;
  } out_item_t;

endpackage

`default_nettype wire

>>> hw/rtl/mlfq_cell.sv
// One queue cell: holds one entry and loads its neighbor's entry on each shift.
`default_nettype none

module mlfq_cell #(
  parameter int LVL_W    = 3,
  parameter int PID_BITS = mlfq_pkg::DEF_PID_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                shift,
  input  wire logic                d_valid,
  input  wire logic [LVL_W-1:0]    d_lvl,
  input  wire logic [PID_BITS-1:0] d_pid,
  output logic                     q_valid,
  output logic [LVL_W-1:0]         q_lvl,
  output logic [PID_BITS-1:0]      q_pid
);

  logic                valid_r;
  logic [LVL_W-1:0]    lvl_r;
  logic [PID_BITS-1:0] pid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift) begin
      valid_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      lvl_r <= d_lvl;
      pid_r <= d_pid;
    end
  end

  assign q_valid = valid_r;
  assign q_lvl   = lvl_r;
  assign q_pid   = pid_r;

endmodule

`default_nettype wire

>>> hw/rtl/mlfq_ctrl.sv
// Ring controller: edits the entry stream as it rotates past the head of the chain.
`default_nettype none

module mlfq_ctrl #(
  parameter int NUM_LEVELS = mlfq_pkg::DEF_NUM_LEVELS,
  parameter int POOL_SLOTS = mlfq_pkg::DEF_POOL_SLOTS,
  parameter int PID_BITS   = mlfq_pkg::DEF_PID_BITS,
  parameter int LVL_W      = $clog2(NUM_LEVELS)
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire mlfq_pkg::in_item_t  in_item,
  output logic                     out_strobe,
  output mlfq_pkg::out_item_t      out_item,
  output logic                     shift,
  input  wire logic                h_valid,
  input  wire logic [LVL_W-1:0]    h_lvl,
  input  wire logic [PID_BITS-1:0] h_pid,
  input  wire logic                n_valid,
  input  wire logic [LVL_W-1:0]    n_lvl,
  input  wire logic [PID_BITS-1:0] n_pid,
  output logic                     y_valid,
  output logic [LVL_W-1:0]         y_lvl,
  output logic [PID_BITS-1:0]      y_pid
);

  localparam int TW   = $clog2(POOL_SLOTS);
  localparam int CNTW = $clog2(POOL_SLOTS + 1);
  localparam int CW   = ((LVL_W > 3) ? LVL_W : 3) + 1;

  mlfq_pkg::state_t    state_r, state_nxt;
  mlfq_pkg::mode_t     mode_r, mode_nxt;
  mlfq_pkg::op_t       op_r, op_nxt;
  mlfq_pkg::out_item_t res_r, res_nxt;
  logic [TW-1:0]       t_r, t_nxt;
  logic [PID_BITS-1:0] pid_r, pid_nxt;
  logic [2:0]          lv_r, lv_nxt;
  logic                hit_r, hit_nxt;
  logic [LVL_W-1:0]    hit_lvl_r, hit_lvl_nxt;
  logic [PID_BITS-1:0] mv_pid_r, mv_pid_nxt;
  logic                skip_r, skip_nxt;
  logic                car_v_r, car_v_nxt;
  logic [LVL_W-1:0]    car_l_r, car_l_nxt;
  logic [PID_BITS-1:0] car_p_r, car_p_nxt;
  logic [CNTW-1:0]     cnt_r, cnt_nxt;

  logic                last;
  logic                nv;
  logic [CW-1:0]       lv_ext;
  logic [CW-1:0]       lv_inc;
  logic [CW-1:0]       h_ext;
  logic [CW-1:0]       n_ext;
  logic [LVL_W-1:0]    lv_ins;

  assign last   = (t_r == TW'(POOL_SLOTS - 1));
  assign nv     = n_valid && !last;
  assign lv_ext = CW'(lv_r);
  assign lv_inc = lv_ext + CW'(1);
  assign h_ext  = CW'(h_lvl);
  assign n_ext  = CW'(n_lvl);
  assign lv_ins = LVL_W'(lv_inc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mlfq_pkg::S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r    <= mode_nxt;
    op_r      <= op_nxt;
    res_r     <= res_nxt;
    t_r       <= t_nxt;
    pid_r     <= pid_nxt;
    lv_r      <= lv_nxt;
    hit_r     <= hit_nxt;
    hit_lvl_r <= hit_lvl_nxt;
    mv_pid_r  <= mv_pid_nxt;
    skip_r    <= skip_nxt;
    car_v_r   <= car_v_nxt;
    car_l_r   <= car_l_nxt;
    car_p_r   <= car_p_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    op_nxt      = op_r;
    res_nxt     = res_r;
    t_nxt       = t_r;
    pid_nxt     = pid_r;
    lv_nxt      = lv_r;
    hit_nxt     = hit_r;
    hit_lvl_nxt = hit_lvl_r;
    mv_pid_nxt  = mv_pid_r;
    skip_nxt    = skip_r;
    car_v_nxt   = car_v_r;
    car_l_nxt   = car_l_r;
    car_p_nxt   = car_p_r;
    cnt_nxt     = cnt_r;
    shift       = 1'b0;
    y_valid     = h_valid;
    y_lvl       = h_lvl;
    y_pid       = h_pid;
    busy        = (state_r == mlfq_pkg::S_PASS);
    out_strobe  = (state_r == mlfq_pkg::S_DONE);
    out_item    = res_r;

    case (state_r)
      mlfq_pkg::S_IDLE, mlfq_pkg::S_DONE: begin
        state_nxt = mlfq_pkg::S_IDLE;
        if (start) begin
          state_nxt = mlfq_pkg::S_PASS;
          op_nxt    = in_item.operation;
          pid_nxt   = PID_BITS'(in_item.process_id);
          lv_nxt    = in_item.level;
          t_nxt     = '0;
          mode_nxt  = mlfq_pkg::MODE_COPY;
          hit_nxt   = 1'b0;
          car_v_nxt = 1'b0;
          skip_nxt  = ((in_item.operation == mlfq_pkg::OP_ADMIT) &&
                       (cnt_r == CNTW'(POOL_SLOTS))) ||
                      ((in_item.operation == mlfq_pkg::OP_DEMOTE) &&
                       ((CW'(in_item.level) + CW'(1)) >= CW'(NUM_LEVELS)));
        end
      end

      mlfq_pkg::S_PASS: begin
        shift = 1'b1;
        t_nxt = t_r + TW'(1);
        case (mode_r)
          mlfq_pkg::MODE_COPY: begin
            if (!hit_r && !skip_r) begin
              case (op_r)
                mlfq_pkg::OP_ADMIT: begin
                  if (!h_valid || (h_lvl != '0)) begin
                    y_valid   = 1'b1;
                    y_lvl     = '0;
                    y_pid     = pid_r;
                    car_v_nxt = h_valid;
                    car_l_nxt = h_lvl;
                    car_p_nxt = h_pid;
                    mode_nxt  = mlfq_pkg::MODE_CARRY;
                    hit_nxt   = 1'b1;
                  end
                end
                mlfq_pkg::OP_DEMOTE: begin
                  if (h_valid && (h_ext == lv_ext)) begin
                    hit_nxt    = 1'b1;
                    mv_pid_nxt = h_pid;
                    if (!nv || (n_ext > lv_inc)) begin
                      y_valid = 1'b1;
                      y_lvl   = lv_ins;
                      y_pid   = h_pid;
                    end else begin
                      y_valid  = n_valid;
                      y_lvl    = n_lvl;
                      y_pid    = n_pid;
                      mode_nxt = mlfq_pkg::MODE_LOOK;
                    end
                  end
                end
                default: begin
                  if (h_valid && (h_pid == pid_r) &&
                      ((op_r == mlfq_pkg::OP_TERM) || (h_ext == lv_ext))) begin
                    hit_nxt     = 1'b1;
                    hit_lvl_nxt = h_lvl;
                    y_valid     = nv;
                    y_lvl       = n_lvl;
                    y_pid       = n_pid;
                    mode_nxt    = mlfq_pkg::MODE_LOOK;
                  end
                end
              endcase
            end
          end
          mlfq_pkg::MODE_LOOK: begin
            if (op_r == mlfq_pkg::OP_DEMOTE) begin
              if (!nv || (n_ext > lv_inc)) begin
                y_valid  = 1'b1;
                y_lvl    = lv_ins;
                y_pid    = mv_pid_r;
                mode_nxt = mlfq_pkg::MODE_COPY;
              end else begin
                y_valid = n_valid;
                y_lvl   = n_lvl;
                y_pid   = n_pid;
              end
            end else begin
              y_valid = nv;
              y_lvl   = n_lvl;
              y_pid   = n_pid;
            end
          end
          mlfq_pkg::MODE_CARRY: begin
            y_valid   = car_v_r;
            y_lvl     = car_l_r;
            y_pid     = car_p_r;
            car_v_nxt = h_valid;
            car_l_nxt = h_lvl;
            car_p_nxt = h_pid;
          end
          default: begin
            mode_nxt = mlfq_pkg::MODE_COPY;
          end
        endcase

        if (last) begin
          state_nxt = mlfq_pkg::S_DONE;
          if ((op_r == mlfq_pkg::OP_ADMIT) && hit_nxt) begin
            cnt_nxt = cnt_r + CNTW'(1);
          end else if (((op_r == mlfq_pkg::OP_TERM) ||
                        (op_r == mlfq_pkg::OP_TERM_LVL)) && hit_nxt) begin
            cnt_nxt = cnt_r - CNTW'(1);
          end
          res_nxt.total_count = 7'(cnt_nxt);
          case (op_r)
            mlfq_pkg::OP_ADMIT: begin
              res_nxt.status       = skip_r ? mlfq_pkg::ST_FULL : mlfq_pkg::ST_OK;
              res_nxt.result_level = 3'd0;
              res_nxt.result_pid   = 16'(pid_r);
            end
            mlfq_pkg::OP_DEMOTE: begin
              if (skip_r) begin
                res_nxt.status = mlfq_pkg::ST_BOTTOM;
              end else if (hit_nxt) begin
                res_nxt.status = mlfq_pkg::ST_OK;
              end else begin
                res_nxt.status = mlfq_pkg::ST_EMPTY;
              end
              res_nxt.result_level = hit_nxt ? 3'(lv_inc) : lv_r;
              res_nxt.result_pid   = hit_nxt ? 16'(mv_pid_nxt) : 16'd0;
            end
            mlfq_pkg::OP_TERM: begin
              res_nxt.status       = hit_nxt ? mlfq_pkg::ST_OK : mlfq_pkg::ST_NOTFOUND;
              res_nxt.result_level = hit_nxt ? 3'(hit_lvl_nxt) : 3'd0;
              res_nxt.result_pid   = 16'(pid_r);
            end
            default: begin
              res_nxt.status       = hit_nxt ? mlfq_pkg::ST_OK : mlfq_pkg::ST_NOTFOUND;
              res_nxt.result_level = lv_r;
              res_nxt.result_pid   = 16'(pid_r);
            end
          endcase
        end
      end

      default: begin
        state_nxt = mlfq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/multilevel_feedback_queue.sv
// Multilevel feedback queue: a ring of entry cells kept sorted by level, then by arrival.
// Busy stays high while the ring rotates once past the controller, one cell per cycle;
// the result is then shown with out_strobe, and no new item is taken while busy.
// A new item is accepted in the cycle its predecessor's result is shown; results are never held.
// Reset (rst_n low, synchronous): all cells empty, entry count zero, controller idle.
`default_nettype none

module multilevel_feedback_queue #(
  parameter int NUM_LEVELS = mlfq_pkg::DEF_NUM_LEVELS,
  parameter int POOL_SLOTS = mlfq_pkg::DEF_POOL_SLOTS,
  parameter int PID_BITS   = mlfq_pkg::DEF_PID_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire mlfq_pkg::in_item_t in_item,
  output logic                    out_strobe,
  output mlfq_pkg::out_item_t     out_item
);

  localparam int LVL_W = $clog2(NUM_LEVELS);

  logic                shift;
  logic                y_valid;
  logic [LVL_W-1:0]    y_lvl;
  logic [PID_BITS-1:0] y_pid;

  logic [POOL_SLOTS-1:0] c_valid;
  logic [LVL_W-1:0]      c_lvl [POOL_SLOTS];
  logic [PID_BITS-1:0]   c_pid [POOL_SLOTS];

  mlfq_ctrl #(
    .NUM_LEVELS (NUM_LEVELS),
    .POOL_SLOTS (POOL_SLOTS),
    .PID_BITS   (PID_BITS),
    .LVL_W      (LVL_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .shift      (shift),
    .h_valid    (c_valid[0]),
    .h_lvl      (c_lvl[0]),
    .h_pid      (c_pid[0]),
    .n_valid    (c_valid[1]),
    .n_lvl      (c_lvl[1]),
    .n_pid      (c_pid[1]),
    .y_valid    (y_valid),
    .y_lvl      (y_lvl),
    .y_pid      (y_pid)
  );

  for (genvar i = 0; i < POOL_SLOTS; i++) begin : g_cell
    if (i == POOL_SLOTS - 1) begin : g_tail
      mlfq_cell #(
        .LVL_W    (LVL_W),
        .PID_BITS (PID_BITS)
      ) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .shift   (shift),
        .d_valid (y_valid),
        .d_lvl   (y_lvl),
        .d_pid   (y_pid),
        .q_valid (c_valid[i]),
        .q_lvl   (c_lvl[i]),
        .q_pid   (c_pid[i])
      );
    end else begin : g_body
      mlfq_cell #(
        .LVL_W    (LVL_W),
        .PID_BITS (PID_BITS)
      ) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .shift   (shift),
        .d_valid (c_valid[i+1]),
        .d_lvl   (c_lvl[i+1]),
        .d_pid   (c_pid[i+1]),
        .q_valid (c_valid[i]),
        .q_lvl   (c_lvl[i]),
        .q_pid   (c_pid[i])
      );
    end
  end

endmodule

`default_nettype wire

>>> dv/tb_multilevel_feedback_queue.sv
// Testbench for the multilevel feedback queue: directed table then random items, scoreboard.
`timescale 1ns / 1ps

module tb_multilevel_feedback_queue;

  localparam int LEVELS     = mlfq_pkg::DEF_NUM_LEVELS;
  localparam int SLOTS      = mlfq_pkg::DEF_POOL_SLOTS;
  localparam int RAND_ITEMS = 500;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_WAIT = SLOTS + 8;

  typedef struct {
    mlfq_pkg::in_item_t  it;
    bit                  typed;
    mlfq_pkg::out_item_t exp;
  } plan_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  mlfq_pkg::in_item_t  in_item = '0;
  logic                busy;
  logic                out_strobe;
  mlfq_pkg::out_item_t out_item;

  logic [15:0] ent_pid  [SLOTS];
  int          ent_link [SLOTS];
  bit          ent_live [SLOTS];
  int          lane_first [LEVELS];
  int          lane_last  [LEVELS];
  int          lane_len   [LEVELS];
  int          spare_first;
  int          spare_len;

  mlfq_pkg::out_item_t pending_results[$];
  plan_row_t           plan[$];
  int                  mismatches = 0;
  int                  idle_cycles = 0;
  int                  burst_left = 0;

  multilevel_feedback_queue u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  always #5 clk = ~clk;

  function automatic void reset_queue();
    for (int i = 0; i < SLOTS; i++) begin
      ent_pid[i]  = '0;
      ent_link[i] = (i + 1 < SLOTS) ? i + 1 : 0;
      ent_live[i] = 1'b0;
    end
    for (int i = 0; i < LEVELS; i++) begin
      lane_first[i] = 0;
      lane_last[i]  = 0;
      lane_len[i]   = 0;
    end
    spare_first = 0;
    spare_len   = SLOTS;
  endfunction

  function automatic void append_entry(int lv, int s);
    if (lane_len[lv] == 0) begin
      lane_first[lv] = s;
    end else begin
      ent_link[lane_last[lv]] = s;
    end
    lane_last[lv] = s;
    lane_len[lv]++;
  endfunction

  function automatic bit unlink_pid(int lv, logic [15:0] pid);
    int cur;
    int prev;
    cur  = lane_first[lv];
    prev = 0;
    for (int n = 0; n < lane_len[lv]; n++) begin
      if (ent_pid[cur] == pid) begin
        if (n == 0) begin
          lane_first[lv] = ent_link[cur];
        end else begin
          ent_link[prev] = ent_link[cur];
        end
        if (n + 1 == lane_len[lv]) begin
          lane_last[lv] = prev;
        end
        lane_len[lv]--;
        ent_link[cur] = spare_first;
        ent_live[cur] = 1'b0;
        spare_first   = cur;
        spare_len++;
        return 1'b1;
      end
      prev = cur;
      cur  = ent_link[cur];
    end
    return 1'b0;
  endfunction

  function automatic mlfq_pkg::out_item_t predict_queue(mlfq_pkg::in_item_t it);
    mlfq_pkg::out_item_t r;
    int                  s;
    int                  lv;
    bit                  hit;
    r   = '0;
    r.status = mlfq_pkg::ST_OK;
    lv  = it.level;
    hit = 1'b0;
    case (it.operation)
      mlfq_pkg::OP_ADMIT: begin
        r.result_pid = it.process_id;
        if (spare_len == 0) begin
          r.status = mlfq_pkg::ST_FULL;
        end else begin
          s           = spare_first;
          spare_first = ent_link[s];
          spare_len--;
          ent_pid[s]  = it.process_id;
          ent_live[s] = 1'b1;
          append_entry(0, s);
        end
      end
      mlfq_pkg::OP_DEMOTE: begin
        r.result_level = it.level;
        if (lv + 1 >= LEVELS) begin
          r.status = mlfq_pkg::ST_BOTTOM;
        end else if (lane_len[lv] == 0) begin
          r.status = mlfq_pkg::ST_EMPTY;
        end else begin
          s              = lane_first[lv];
          lane_first[lv] = ent_link[s];
          lane_len[lv]--;
          append_entry(lv + 1, s);
          r.result_level = 3'(lv + 1);
          r.result_pid   = ent_pid[s];
        end
      end
      mlfq_pkg::OP_TERM: begin
        r.result_pid = it.process_id;
        r.status     = mlfq_pkg::ST_NOTFOUND;
        for (int i = 0; i < LEVELS && !hit; i++) begin
          if (unlink_pid(i, it.process_id)) begin
            hit            = 1'b1;
            r.status       = mlfq_pkg::ST_OK;
            r.result_level = 3'(i);
          end
        end
      end
      default: begin
        r.result_pid   = it.process_id;
        r.result_level = it.level;
        r.status       = mlfq_pkg::ST_NOTFOUND;
        if (lv < LEVELS && unlink_pid(lv, it.process_id)) begin
          r.status = mlfq_pkg::ST_OK;
        end
      end
    endcase
    r.total_count = 7'(SLOTS - spare_len);
    return r;
  endfunction

  function automatic logic [15:0] pick_live_pid();
    int s;
    int k;
    s = $urandom_range(0, SLOTS - 1);
    for (k = 0; k < SLOTS; k++) begin
      if (ent_live[(s + k) % SLOTS]) begin
        return ent_pid[(s + k) % SLOTS];
      end
    end
    return 16'($urandom);
  endfunction

  function automatic logic [2:0] pick_full_level();
    int s;
    int k;
    s = $urandom_range(0, LEVELS - 1);
    for (k = 0; k < LEVELS; k++) begin
      if (lane_len[(s + k) % LEVELS] != 0) begin
        return 3'((s + k) % LEVELS);
      end
    end
    return 3'($urandom);
  endfunction

  function automatic mlfq_pkg::in_item_t make_item(bit filling);
    mlfq_pkg::in_item_t it;
    int                 roll;
    it.operation  = mlfq_pkg::op_t'($urandom_range(0, 3));
    it.process_id = 16'($urandom);
    it.level      = 3'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      return it;
    end
    roll = $urandom_range(0, 99);
    if (filling) begin
      it.operation = (roll < 75) ? mlfq_pkg::OP_ADMIT : (roll < 88) ? mlfq_pkg::OP_DEMOTE :
                     (roll < 94) ? mlfq_pkg::OP_TERM : mlfq_pkg::OP_TERM_LVL;
    end else begin
      it.operation = (roll < 15) ? mlfq_pkg::OP_ADMIT : (roll < 40) ? mlfq_pkg::OP_DEMOTE :
                     (roll < 70) ? mlfq_pkg::OP_TERM : mlfq_pkg::OP_TERM_LVL;
    end
    case (it.operation)
      mlfq_pkg::OP_ADMIT: begin
        if ($urandom_range(0, 3) == 0) begin
          it.process_id = 16'($urandom_range(0, 7));
        end
      end
      mlfq_pkg::OP_DEMOTE: begin
        if ($urandom_range(0, 9) < 7) begin
          it.level = pick_full_level();
        end
      end
      default: begin
        if ($urandom_range(0, 9) < 8) begin
          it.process_id = pick_live_pid();
        end
        if (it.operation == mlfq_pkg::OP_TERM_LVL && $urandom_range(0, 9) < 6) begin
          it.level = pick_full_level();
        end
      end
    endcase
    return it;
  endfunction

  task automatic add_row(mlfq_pkg::op_t op, logic [15:0] pid, logic [2:0] lv, bit typed,
                         mlfq_pkg::status_t st, logic [2:0] rl, logic [15:0] rp,
                         logic [6:0] tc);
    plan_row_t row;
    row.it.operation    = op;
    row.it.process_id   = pid;
    row.it.level        = lv;
    row.typed           = typed;
    row.exp.status       = st;
    row.exp.result_level = rl;
    row.exp.result_pid   = rp;
    row.exp.total_count  = tc;
    plan.push_back(row);
  endtask

  task automatic send_item(mlfq_pkg::in_item_t it, bit typed, mlfq_pkg::out_item_t exp);
    mlfq_pkg::out_item_t pred;
    int                  gap;
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    pred = predict_queue(it);
    pending_results.push_back(typed ? exp : pred);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
      gap = $urandom_range(1, 90);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d level %0d pid %h count %0d",
               out_item.status, out_item.result_level, out_item.result_pid,
               out_item.total_count);
        mismatches++;
      end else begin
        mlfq_pkg::out_item_t want;
        want = pending_results.pop_front();
        if (out_item.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_item.status);
          mismatches++;
        end
        if (out_item.result_level !== want.result_level) begin
          $error("result_level: expected %0d, actual %0d",
                 want.result_level, out_item.result_level);
          mismatches++;
        end
        if (out_item.result_pid !== want.result_pid) begin
          $error("result_pid: expected %h, actual %h", want.result_pid, out_item.result_pid);
          mismatches++;
        end
        if (out_item.total_count !== want.total_count) begin
          $error("total_count: expected %0d, actual %0d",
                 want.total_count, out_item.total_count);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || out_strobe || (start && !busy)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    bit filling;
    int phase_left;
    reset_queue();
    add_row(mlfq_pkg::OP_DEMOTE, 16'h0000, 3'd0, 1,
            mlfq_pkg::ST_EMPTY, 3'd0, 16'h0000, 7'd0);
    add_row(mlfq_pkg::OP_DEMOTE, 16'hFFFF, 3'd7, 1,
            mlfq_pkg::ST_BOTTOM, 3'd7, 16'h0000, 7'd0);
    add_row(mlfq_pkg::OP_DEMOTE, 16'h0000, 3'd6, 1,
            mlfq_pkg::ST_EMPTY, 3'd6, 16'h0000, 7'd0);
    add_row(mlfq_pkg::OP_TERM, 16'hFFFF, 3'd0, 1,
            mlfq_pkg::ST_NOTFOUND, 3'd0, 16'hFFFF, 7'd0);
    add_row(mlfq_pkg::OP_TERM_LVL, 16'h0000, 3'd5, 1,
            mlfq_pkg::ST_NOTFOUND, 3'd5, 16'h0000, 7'd0);
    add_row(mlfq_pkg::OP_ADMIT, 16'hFFFF, 3'd7, 1,
            mlfq_pkg::ST_OK, 3'd0, 16'hFFFF, 7'd1);
    add_row(mlfq_pkg::OP_ADMIT, 16'h0000, 3'd0, 1,
            mlfq_pkg::ST_OK, 3'd0, 16'h0000, 7'd2);
    add_row(mlfq_pkg::OP_ADMIT, 16'hFFFF, 3'd0, 1,
            mlfq_pkg::ST_OK, 3'd0, 16'hFFFF, 7'd3);
    add_row(mlfq_pkg::OP_ADMIT, 16'h1234, 3'd0, 1,
            mlfq_pkg::ST_OK, 3'd0, 16'h1234, 7'd4);
    add_row(mlfq_pkg::OP_DEMOTE, 16'h0000, 3'd0, 1,
            mlfq_pkg::ST_OK, 3'd1, 16'hFFFF, 7'd4);
    add_row(mlfq_pkg::OP_DEMOTE, 16'h0000, 3'd1, 1,
            mlfq_pkg::ST_OK, 3'd2, 16'hFFFF, 7'd4);
    add_row(mlfq_pkg::OP_TERM, 16'hFFFF, 3'd0, 1,
            mlfq_pkg::ST_OK, 3'd0, 16'hFFFF, 7'd3);
    add_row(mlfq_pkg::OP_TERM_LVL, 16'hFFFF, 3'd0, 1,
            mlfq_pkg::ST_NOTFOUND, 3'd0, 16'hFFFF, 7'd3);
    add_row(mlfq_pkg::OP_TERM_LVL, 16'hFFFF, 3'd2, 1,
            mlfq_pkg::ST_OK, 3'd2, 16'hFFFF, 7'd2);
    add_row(mlfq_pkg::OP_DEMOTE, 16'h0000, 3'd0, 1,
            mlfq_pkg::ST_OK, 3'd1, 16'h0000, 7'd2);
    add_row(mlfq_pkg::OP_TERM_LVL, 16'h0000, 3'd1, 1,
            mlfq_pkg::ST_OK, 3'd1, 16'h0000, 7'd1);
    add_row(mlfq_pkg::OP_TERM, 16'h1234, 3'd0, 1,
            mlfq_pkg::ST_OK, 3'd0, 16'h1234, 7'd0);
    add_row(mlfq_pkg::OP_TERM, 16'h1234, 3'd0, 1,
            mlfq_pkg::ST_NOTFOUND, 3'd0, 16'h1234, 7'd0);
    add_row(mlfq_pkg::OP_ADMIT, 16'hA5A5, 3'd0, 0,
            mlfq_pkg::ST_OK, 3'd0, 16'h0000, 7'd0);
    for (int lv = 0; lv < LEVELS; lv++) begin
      add_row(mlfq_pkg::OP_DEMOTE, 16'h5A5A, 3'(lv), 0,
              mlfq_pkg::ST_OK, 3'd0, 16'h0000, 7'd0);
    end
    add_row(mlfq_pkg::OP_TERM, 16'hA5A5, 3'd0, 1,
            mlfq_pkg::ST_OK, 3'd7, 16'hA5A5, 7'd0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      send_item(plan[i].it, plan[i].typed, plan[i].exp);
    end

    filling    = 1'b0;
    phase_left = 0;
    for (int k = 0; k < RAND_ITEMS; k++) begin
      if (phase_left == 0) begin
        filling    = !filling;
        phase_left = filling ? $urandom_range(90, 140) : $urandom_range(40, 110);
      end
      phase_left--;
      send_item(make_item(filling), 1'b0, '0);
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
